>>> rtl/idta_pkg.sv
// Package for the decimal text converter.
// Holds the controller state type, the cell control group and the ASCII codes.
`default_nettype none
package idta_pkg;

    localparam logic [5:0] CH_ZERO  = 6'd48;
    localparam logic [5:0] CH_MINUS = 6'd45;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic dabble;
        logic dshift;
    } t_cell_ctl;

endpackage
`default_nettype wire

>>> rtl/idta_cell.sv
// One BCD digit cell of the converter row.
// Shifts one binary bit per cycle with add-3 correction, or moves whole digits
// toward the top of the row. Uses idta_pkg.
`default_nettype none
module idta_cell (
    input  wire logic               i_clk,
    input  wire idta_pkg::t_cell_ctl i_ctl,
    input  wire logic               i_carry,
    input  wire logic [3:0]         i_digit,
    output logic                    o_carry,
    output logic [3:0]              o_digit
);
    import idta_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_adj;

    always_comb begin
        if (r_digit inside {[4'd5:4'd15]}) begin
            w_adj = r_digit + 4'd3;
        end else begin
            w_adj = r_digit;
        end
    end

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.dabble) begin
            n_digit = {w_adj[2:0], i_carry};
        end else if (i_ctl.dshift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

    assign o_carry = w_adj[3];
    assign o_digit = r_digit;

endmodule
`default_nettype wire

>>> rtl/int64_to_decimal_ascii.sv
// Top level of the binary to decimal ASCII converter.
// Controller, magnitude shifter and the row of idta_cell digit cells. Uses idta_pkg.
//
// Converts one DATA_WIDTH-bit word, read as signed or unsigned, into its decimal
// text, most significant character first, with a leading '-' for negative values
// and o_last on the final character. One item is handled at a time: after
// acceptance the DATA_WIDTH magnitude bits are shifted one by one through the
// digit cell row, then leading zero digits are dropped at one per cycle (up to
// NDIG-1 digits, NDIG = digits of the largest unsigned word), then one character
// leaves per cycle while the consumer is ready. The next item is taken once the
// last character sits in the output register.
`default_nettype none
module int64_to_decimal_ascii #(
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic [DATA_WIDTH-1:0] i_value,
    input  wire logic                  i_is_signed,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [5:0]                 o_char_code,
    output logic                       o_last
);
    import idta_pkg::*;

    localparam int NDIG = ((DATA_WIDTH * 1233) >> 12) + 1;
    localparam int BW   = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;
    localparam int NW   = $clog2(NDIG + 1);

    t_state               r_state, n_state;
    logic [DATA_WIDTH-1:0] r_mag, n_mag;
    logic                 r_neg, n_neg;
    logic [BW-1:0]        r_bcnt, n_bcnt;
    logic [NW-1:0]        r_nd, n_nd;
    logic                 r_ovalid, n_ovalid;
    logic [5:0]           r_ochar, n_ochar;
    logic                 r_olast, n_olast;
    t_cell_ctl            w_ctl;

    logic [NDIG:0]        w_carry;
    logic [3:0]           w_digit [NDIG+1];

    logic                 w_in_neg;
    logic                 w_out_free;
    logic [3:0]           w_top;

    assign w_carry[0] = r_mag[DATA_WIDTH-1];
    assign w_digit[0] = 4'd0;
    assign w_top      = w_digit[NDIG];

    for (genvar g = 0; g < NDIG; g++) begin : g_cell
        idta_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_carry (w_carry[g]),
            .i_digit (w_digit[g]),
            .o_carry (w_carry[g+1]),
            .o_digit (w_digit[g+1])
        );
    end

    assign w_in_neg   = i_is_signed & i_value[DATA_WIDTH-1];
    assign w_out_free = ~r_ovalid | i_ready;
    assign o_ready    = (r_state == ST_IDLE);

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_neg    = r_neg;
        n_bcnt   = r_bcnt;
        n_nd     = r_nd;
        n_ovalid = r_ovalid & ~i_ready;
        n_ochar  = r_ochar;
        n_olast  = r_olast;
        w_ctl    = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_mag     = w_in_neg ? (~i_value + 1'b1) : i_value;
                    n_neg     = w_in_neg;
                    n_bcnt    = BW'(DATA_WIDTH - 1);
                    n_nd      = NW'(NDIG);
                    w_ctl.clear = 1'b1;
                    n_state   = ST_CONV;
                end
            end
            ST_CONV: begin
                w_ctl.dabble = 1'b1;
                n_mag        = {r_mag[DATA_WIDTH-2:0], 1'b0};
                n_bcnt       = r_bcnt - 1'b1;
                if (r_bcnt == '0) begin
                    n_state = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((w_top == 4'd0) && (r_nd != NW'(1))) begin
                    w_ctl.dshift = 1'b1;
                    n_nd         = r_nd - 1'b1;
                end else if (r_neg) begin
                    n_state = ST_SIGN;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_SIGN: begin
                if (w_out_free) begin
                    n_ovalid = 1'b1;
                    n_ochar  = CH_MINUS;
                    n_olast  = 1'b0;
                    n_state  = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_ovalid     = 1'b1;
                    n_ochar      = CH_ZERO + {2'b00, w_top};
                    n_olast      = (r_nd == NW'(1));
                    w_ctl.dshift = 1'b1;
                    n_nd         = r_nd - 1'b1;
                    if (r_nd == NW'(1)) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_mag   <= n_mag;
        r_neg   <= n_neg;
        r_bcnt  <= n_bcnt;
        r_nd    <= n_nd;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

    assign o_valid     = r_ovalid;
    assign o_char_code = r_ochar;
    assign o_last      = r_olast;

endmodule
`default_nettype wire

>>> rtl/idta_checker.sv
// Port-level checker for the decimal text converter, bound to the top level.
// Uses idta_pkg for the ASCII codes.
`default_nettype none
module idta_checker #(
    parameter int DATA_WIDTH = 64
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_valid,
    input wire logic                  o_ready,
    input wire logic [DATA_WIDTH-1:0] i_value,
    input wire logic                  i_is_signed,
    input wire logic                  o_valid,
    input wire logic                  i_ready,
    input wire logic [5:0]            o_char_code,
    input wire logic                  o_last
);
    import idta_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_char_code) && $stable(o_last))
        else $error("output item changed while stalled");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_char_code == CH_MINUS) ||
                    ((o_char_code >= CH_ZERO) && (o_char_code <= CH_ZERO + 6'd9)))
        else $error("character code out of range");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_char_code == CH_MINUS) |-> !o_last)
        else $error("minus sign marked as last character");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready && !(o_valid && o_last && $changed(o_char_code)))
        else $error("input taken while an item is in progress");

    logic w_unused;
    assign w_unused = ^{i_value, i_is_signed};

endmodule

bind int64_to_decimal_ascii idta_checker #(.DATA_WIDTH(DATA_WIDTH)) u_idta_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_ready     (o_ready),
    .i_value     (i_value),
    .i_is_signed (i_is_signed),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_char_code (o_char_code),
    .o_last      (o_last)
);
`default_nettype wire

>>> dv/tb_top.sv
// Testbench for int64_to_decimal_ascii: random and directed 64-bit words in, decimal text out.
// Self-checking against an in-bench digit predictor, with bursty input and a stalling receiver.
// Depends on idta_pkg and the int64_to_decimal_ascii RTL.
`default_nettype none
module tb_top;
    import idta_pkg::*;

    localparam int LIMIT      = 1000000;
    localparam int N_RANDOM   = 448;
    localparam int HOLD_AFTER = 30;
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [63:0] value;
        logic        is_signed;
    } t_word_item;

    typedef struct packed {
        logic [5:0] code;
        logic       last;
    } t_text_char;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_MOSTLY,
        RDY_PERIODIC
    } t_rdy_mode;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [63:0] i_value     = 64'd0;
    logic        i_is_signed = 1'b0;
    logic        i_ready     = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [5:0]  o_char_code;
    logic        o_last;

    t_word_item pending_words[$];
    t_text_char text_q[$];

    logic      in_taken   = 1'b0;
    int        cycles     = 0;
    int        n_errors   = 0;
    int        n_accepted = 0;
    int        burst_left = 0;
    int        gap_left   = 0;
    int        hold_left  = 0;
    logic      hold_done  = 1'b0;
    t_rdy_mode rdy_mode   = RDY_ALWAYS;
    int        mode_left  = 0;
    logic [63:0] pow10[20];

    int64_to_decimal_ascii #(
        .DATA_WIDTH(64)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_value(i_value),
        .i_is_signed(i_is_signed),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_char_code(o_char_code),
        .o_last(o_last)
    );

    function automatic void predict_text(input logic [63:0] word, input logic signed_mode);
        logic [63:0] mag;
        logic [63:0] rem;
        logic        neg;
        logic [3:0]  digs[$];
        int          k;
        neg = signed_mode && word[63];
        mag = neg ? (~word + 64'd1) : word;
        if (mag == 64'd0) begin
            text_q.push_back('{code: CH_ZERO, last: 1'b1});
        end else begin
            while (mag != 64'd0) begin
                rem = mag % 64'd10;
                digs.push_back(rem[3:0]);
                mag = mag / 64'd10;
            end
            if (neg) begin
                text_q.push_back('{code: CH_MINUS, last: 1'b0});
            end
            for (k = digs.size() - 1; k >= 0; k--) begin
                text_q.push_back('{code: CH_ZERO + {2'b00, digs[k]}, last: (k == 0)});
            end
        end
    endfunction

    function automatic logic [63:0] random_word();
        logic [63:0] w;
        case ($urandom_range(0, 5))
            0: w = {$urandom, $urandom};
            1: w = {$urandom, $urandom} >> $urandom_range(0, 63);
            2: w = 64'($urandom_range(0, 1000));
            3: w = pow10[$urandom_range(0, 19)] + 64'($urandom_range(0, 2)) - 64'd1;
            4: w = 64'd0 - 64'($urandom_range(0, 1000));
            default: begin
                case ($urandom_range(0, 3))
                    0: w = 64'd0;
                    1: w = {64{1'b1}};
                    2: w = 64'h8000_0000_0000_0000;
                    default: w = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
        endcase
        return w;
    endfunction

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin : monitor
        t_text_char want;
        cycles   <= cycles + 1;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (text_q.size() == 0) begin
                    $display("%0t: unexpected char: expected none, actual code %0d last %0b",
                             $time, o_char_code, o_last);
                    n_errors++;
                end else begin
                    want = text_q.pop_front();
                    if (o_char_code !== want.code) begin
                        $display("%0t: char_code mismatch: expected %0d, actual %0d",
                                 $time, want.code, o_char_code);
                        n_errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0b, actual %0b",
                                 $time, want.last, o_last);
                        n_errors++;
                    end
                end
            end
            if (i_valid && o_ready) begin
                predict_text(i_value, i_is_signed);
                n_accepted <= n_accepted + 1;
            end
        end
    end

    always @(negedge i_clk) begin : driver
        t_word_item item;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else if (i_valid && !in_taken) begin
            // hold the offered item
        end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            i_valid  <= 1'b0;
        end else if (pending_words.size() == 0) begin
            i_valid <= 1'b0;
        end else begin
            item = pending_words.pop_front();
            i_value     <= item.value;
            i_is_signed <= item.is_signed;
            i_valid     <= 1'b1;
            if (burst_left <= 1) begin
                burst_left <= $urandom_range(1, 8);
                if ($urandom_range(0, 3) == 0)
                    gap_left <= $urandom_range(1, 120);
                else if ($urandom_range(0, 1) == 0)
                    gap_left <= 0;
                else
                    gap_left <= $urandom_range(1, 5);
            end else begin
                burst_left <= burst_left - 1;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_ready   <= 1'b0;
        end else if (!hold_done && n_accepted >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            i_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                rdy_mode  <= t_rdy_mode'($urandom_range(0, 3));
                mode_left <= $urandom_range(20, 200);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (rdy_mode)
                RDY_ALWAYS: i_ready <= 1'b1;
                RDY_COIN:   i_ready <= 1'($urandom_range(0, 1));
                RDY_MOSTLY: i_ready <= ($urandom_range(0, 3) != 0);
                default:    i_ready <= cycles[2];
            endcase
        end
    end

    initial begin : stimulus
        int k;
        t_word_item item;
        pow10[0] = 64'd1;
        for (k = 1; k < 20; k++) pow10[k] = pow10[k-1] * 64'd10;

        pending_words.push_back('{value: 64'd0, is_signed: 1'b0});
        pending_words.push_back('{value: 64'd0, is_signed: 1'b1});
        pending_words.push_back('{value: 64'd1, is_signed: 1'b0});
        pending_words.push_back('{value: 64'd9, is_signed: 1'b1});
        pending_words.push_back('{value: 64'd10, is_signed: 1'b0});
        pending_words.push_back('{value: {64{1'b1}}, is_signed: 1'b0});
        pending_words.push_back('{value: {64{1'b1}}, is_signed: 1'b1});
        pending_words.push_back('{value: 64'h8000_0000_0000_0000, is_signed: 1'b1});
        pending_words.push_back('{value: 64'h8000_0000_0000_0000, is_signed: 1'b0});
        pending_words.push_back('{value: 64'h7FFF_FFFF_FFFF_FFFF, is_signed: 1'b1});
        pending_words.push_back('{value: 64'h7FFF_FFFF_FFFF_FFFF, is_signed: 1'b0});
        pending_words.push_back('{value: 64'h8000_0000_0000_0001, is_signed: 1'b1});
        pending_words.push_back('{value: pow10[19], is_signed: 1'b0});
        pending_words.push_back('{value: pow10[19] - 64'd1, is_signed: 1'b0});
        pending_words.push_back('{value: pow10[18], is_signed: 1'b1});
        pending_words.push_back('{value: 64'd0 - pow10[18], is_signed: 1'b1});
        pending_words.push_back('{value: 64'd0 - 64'd10, is_signed: 1'b1});
        pending_words.push_back('{value: 64'd0 - 64'd10, is_signed: 1'b0});
        pending_words.push_back('{value: 64'd100, is_signed: 1'b1});
        pending_words.push_back('{value: 64'hAAAA_AAAA_AAAA_AAAA, is_signed: 1'b1});
        pending_words.push_back('{value: 64'h5555_5555_5555_5555, is_signed: 1'b0});
        pending_words.push_back('{value: 64'd12345678901234567890, is_signed: 1'b0});
        for (k = 0; k < N_RANDOM; k++) begin
            item.value     = random_word();
            item.is_signed = 1'($urandom_range(0, 1));
            pending_words.push_back(item);
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pending_words.size() == 0 && !i_valid && text_q.size() == 0)
               && cycles < LIMIT)
            @(posedge i_clk);

        if (cycles >= LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            repeat (100) @(posedge i_clk);
            if (text_q.size() != 0) begin
                $display("%0t: %0d expected chars never arrived", $time, text_q.size());
                n_errors++;
            end
            if (n_errors == 0)
                $display("ALL CHECKS PASSED");
            else
                $display("CHECKS FAILED");
            $finish;
        end
    end

endmodule
`default_nettype wire
